@@ src/lphs_pkg.sv @@
package lphs_pkg;

  localparam int unsigned SLOTS_DEF  = 16;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned MARK_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HASH_STEPS = KEY_W / BYTE_W;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic clr;
    logic load;
    logic hash;
    logic probe;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic probe_done;
    logic out_free;
  } stat_t;

endpackage

@@ src/linear_probing_hash_set.sv @@
// The key is reduced to its home slot a byte at a time, then the probe checks
// one slot per cycle, up to SLOTS slots, until the operation is settled.
// A new input word is taken only after the result of the last one has been
// moved into the output register.
// Reset: asynchronous and active low; afterwards a clearing pass marks every
// slot empty before the first input word is taken.
module linear_probing_hash_set #(
  parameter int unsigned SLOTS = lphs_pkg::SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [lphs_pkg::KEY_W-1:0]        s_axis_tdata_i,  // [31:0] key
  input  logic [lphs_pkg::KIND_W-1:0]       s_axis_tuser_i,  // [1:0] kind
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [lphs_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,  // [1:0] status, [7:2] zero
  output logic                              m_axis_tuser_o   // [0] success
);

  lphs_pkg::cmd_t                cmd;
  lphs_pkg::stat_t               stat;
  logic [lphs_pkg::STATUS_W-1:0] status;

  lphs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lphs_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .kind_i      (s_axis_tuser_i),
    .key_i       (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .success_o   (m_axis_tuser_o),
    .status_o    (status)
  );

  assign m_axis_tdata_o = {{(lphs_pkg::OUT_DATA_W - lphs_pkg::STATUS_W){1'b0}}, status};

endmodule

@@ src/lphs_ram.sv @@
module lphs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lphs_ctrl.sv @@
module lphs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lphs_pkg::stat_t stat_i,
  output lphs_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_HASH;
      end
      S_HASH: begin
        if (stat_i.hash_last) state_d = S_PROBE;
      end
      S_PROBE: begin
        if (stat_i.probe_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.clr     = (state_q == S_CLEAR);
  assign cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.hash    = (state_q == S_HASH);
  assign cmd_o.probe   = (state_q == S_PROBE);
  assign cmd_o.commit  = (state_q == S_DONE) && stat_i.out_free;

endmodule

@@ src/lphs_dp.sv @@
module lphs_dp #(
  parameter int unsigned SLOTS = lphs_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lphs_pkg::cmd_t                  cmd_i,
  output lphs_pkg::stat_t                 stat_o,
  input  logic [lphs_pkg::KIND_W-1:0]     kind_i,
  input  logic [lphs_pkg::KEY_W-1:0]      key_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            success_o,
  output logic [lphs_pkg::STATUS_W-1:0]   status_o
);

  localparam int unsigned IW  = $clog2(SLOTS);
  localparam int unsigned HCW = $clog2(lphs_pkg::HASH_STEPS);
  localparam logic [IW:0]     SlotsW  = (IW+1)'(SLOTS);
  localparam logic [IW-1:0]   LastIdx = IW'(SLOTS - 1);
  localparam logic [HCW-1:0]  LastHash = HCW'(lphs_pkg::HASH_STEPS - 1);

  logic [lphs_pkg::KIND_W-1:0]   kind_q;
  logic [lphs_pkg::KEY_W-1:0]    key_q;
  logic [lphs_pkg::KEY_W-1:0]    mag_q;
  logic                          neg_q;
  logic [IW-1:0]                 rem_q;
  logic [HCW-1:0]                hcnt_q;
  logic [IW-1:0]                 idx_q;
  logic [IW-1:0]                 rd_idx_q;
  logic                          rd_vld_q;
  logic [IW-1:0]                 eval_q;
  logic                          have_tomb_q;
  logic [IW-1:0]                 tomb_q;
  logic [IW-1:0]                 clr_q;
  logic                          pend_succ_q;
  logic [lphs_pkg::STATUS_W-1:0] pend_st_q;
  logic                          pend_we_q;
  logic                          pend_kwe_q;
  logic [IW-1:0]                 pend_addr_q;
  logic [lphs_pkg::MARK_W-1:0]   pend_mark_q;
  logic                          out_valid_q;
  logic                          out_succ_q;
  logic [lphs_pkg::STATUS_W-1:0] out_st_q;

  logic [IW-1:0]                 rem_nx;
  logic [IW-1:0]                 start_nx;
  logic [IW-1:0]                 idx_nx;
  logic [lphs_pkg::MARK_W-1:0]   mark_rd;
  logic [lphs_pkg::KEY_W-1:0]    key_rd;

  logic                          done;
  logic                          succ;
  logic [lphs_pkg::STATUS_W-1:0] st;
  logic                          we;
  logic                          kwe;
  logic [IW-1:0]                 waddr;
  logic [lphs_pkg::MARK_W-1:0]   wmark;
  logic                          tomb_take;
  logic                          last;
  logic                          hit;

  logic                          mark_we;
  logic [IW-1:0]                 mark_waddr;
  logic [lphs_pkg::MARK_W-1:0]   mark_wdata;

  // The home slot is reduced one byte of the key magnitude per cycle, most
  // significant byte first, with one compare and subtract per bit.
  always_comb begin
    logic [IW:0] r;
    r = {1'b0, rem_q};
    for (int b = 0; b < lphs_pkg::BYTE_W; b++) begin
      r = {r[IW-1:0], mag_q[lphs_pkg::KEY_W-1-b]};
      if (r >= SlotsW) begin
        r = r - SlotsW;
      end
    end
    rem_nx = r[IW-1:0];
  end

  assign start_nx = (neg_q && (rem_nx != '0)) ? IW'(SlotsW - {1'b0, rem_nx}) : rem_nx;
  assign idx_nx   = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;

  assign last = (eval_q == LastIdx);
  assign hit  = (mark_rd == lphs_pkg::MARK_USED) && (key_rd == key_q);

  always_comb begin
    done      = 1'b0;
    succ      = 1'b0;
    st        = lphs_pkg::ST_DONE;
    we        = 1'b0;
    kwe       = 1'b0;
    waddr     = rd_idx_q;
    wmark     = lphs_pkg::MARK_USED;
    tomb_take = 1'b0;
    if (rd_vld_q) begin
      case (kind_q)
        lphs_pkg::KIND_INSERT: begin
          if (hit) begin
            done = 1'b1;
            st   = lphs_pkg::ST_DUP;
          end else begin
            tomb_take = (mark_rd == lphs_pkg::MARK_DELETED) && !have_tomb_q;
            if (mark_rd == lphs_pkg::MARK_EMPTY || (last && (have_tomb_q || tomb_take))) begin
              done  = 1'b1;
              succ  = 1'b1;
              we    = 1'b1;
              kwe   = 1'b1;
              waddr = have_tomb_q ? tomb_q : rd_idx_q;
            end else if (last) begin
              done = 1'b1;
              st   = lphs_pkg::ST_FULL;
            end
          end
        end
        lphs_pkg::KIND_FIND, lphs_pkg::KIND_DELETE: begin
          if (mark_rd == lphs_pkg::MARK_EMPTY) begin
            done = 1'b1;
            st   = lphs_pkg::ST_MISSING;
          end else if (hit) begin
            done  = 1'b1;
            succ  = 1'b1;
            we    = (kind_q == lphs_pkg::KIND_DELETE);
            wmark = lphs_pkg::MARK_DELETED;
          end else if (last) begin
            done = 1'b1;
            st   = lphs_pkg::ST_MISSING;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q      <= '0;
      rd_vld_q    <= 1'b0;
      eval_q      <= '0;
      have_tomb_q <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.load) begin
        hcnt_q      <= '0;
        rd_vld_q    <= 1'b0;
        eval_q      <= '0;
        have_tomb_q <= 1'b0;
      end
      if (cmd_i.hash) begin
        hcnt_q <= hcnt_q + 1'b1;
      end
      if (cmd_i.probe) begin
        rd_vld_q <= 1'b1;
        if (rd_vld_q) begin
          eval_q <= eval_q + 1'b1;
        end
        if (tomb_take) begin
          have_tomb_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      key_q  <= key_i;
      neg_q  <= key_i[lphs_pkg::KEY_W-1];
      mag_q  <= key_i[lphs_pkg::KEY_W-1] ? (~key_i + 1'b1) : key_i;
      rem_q  <= '0;
    end
    if (cmd_i.hash) begin
      mag_q <= mag_q << lphs_pkg::BYTE_W;
      rem_q <= rem_nx;
      if (hcnt_q == LastHash) begin
        idx_q <= start_nx;
      end
    end
    if (cmd_i.probe) begin
      idx_q    <= idx_nx;
      rd_idx_q <= idx_q;
      if (tomb_take) begin
        tomb_q <= rd_idx_q;
      end
      if (done) begin
        pend_succ_q <= succ;
        pend_st_q   <= st;
        pend_we_q   <= we;
        pend_kwe_q  <= kwe;
        pend_addr_q <= waddr;
        pend_mark_q <= wmark;
      end
    end
    if (cmd_i.commit) begin
      out_succ_q <= pend_succ_q;
      out_st_q   <= pend_st_q;
    end
  end

  assign mark_we    = cmd_i.clr || (cmd_i.commit && pend_we_q);
  assign mark_waddr = cmd_i.clr ? clr_q : pend_addr_q;
  assign mark_wdata = cmd_i.clr ? lphs_pkg::MARK_EMPTY : pend_mark_q;

  lphs_ram #(
    .WIDTH (lphs_pkg::MARK_W),
    .DEPTH (SLOTS)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .re_i    (cmd_i.probe),
    .raddr_i (idx_q),
    .rdata_o (mark_rd)
  );

  lphs_ram #(
    .WIDTH (lphs_pkg::KEY_W),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && pend_kwe_q),
    .waddr_i (pend_addr_q),
    .wdata_i (key_q),
    .re_i    (cmd_i.probe),
    .raddr_i (idx_q),
    .rdata_o (key_rd)
  );

  assign stat_o.clr_last   = (clr_q == LastIdx);
  assign stat_o.hash_last  = (hcnt_q == LastHash);
  assign stat_o.probe_done = done;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign success_o   = out_succ_q;
  assign status_o    = out_st_q;

endmodule

@@ src/lphs_checker.sv @@
module lphs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [lphs_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tuser_o
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // A successful operation always reports the done status.
  a_succ_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o[lphs_pkg::STATUS_W-1:0] == lphs_pkg::ST_DONE)
    else $error("success reported with a failure status");

  // The padding above the status field stays zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[lphs_pkg::OUT_DATA_W-1:lphs_pkg::STATUS_W] == '0)
    else $error("result padding is not zero");

  // The block works on one operation at a time.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken again while an operation is in progress");

endmodule

bind linear_probing_hash_set lphs_checker u_lphs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

@@ tb/sv/linear_probing_hash_set_test.sv @@
`timescale 1ns / 100ps

module linear_probing_hash_set_test;
  import lphs_pkg::*;

  localparam int SLOTS = 16;
  localparam int POOL = 20;
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  typedef struct packed {
    logic                success;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  class key_set_checker;
    logic [MARK_W-1:0] slot_mark [SLOTS];
    logic [KEY_W-1:0]  slot_key [SLOTS];
    outcome_t          pending_outcomes [$];
    int unsigned       failures;

    function new();
      foreach (slot_mark[i]) begin
        slot_mark[i] = MARK_EMPTY;
        slot_key[i] = '0;
      end
      failures = 0;
    endfunction

    function int unsigned home_slot(logic [KEY_W-1:0] key);
      int r;
      r = $signed(key) % SLOTS;
      if (r < 0) begin
        r += SLOTS;
      end
      return r;
    endfunction

    // Walks one lap from the home slot and updates the table as the block should.
    function outcome_t predict_outcome(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
      int unsigned start, idx, tomb;
      bit have_tomb;
      outcome_t res;
      start = home_slot(key);
      have_tomb = 1'b0;
      tomb = 0;
      res.success = 1'b0;
      res.status = ST_DONE;
      if (kind == KIND_INSERT) begin
        for (int unsigned step = 0; step < SLOTS; step++) begin
          idx = (start + step) % SLOTS;
          if (slot_mark[idx] == MARK_USED && slot_key[idx] == key) begin
            res.status = ST_DUP;
            return res;
          end
          if (slot_mark[idx] == MARK_DELETED && !have_tomb) begin
            have_tomb = 1'b1;
            tomb = idx;
          end
          if (slot_mark[idx] == MARK_EMPTY) begin
            if (have_tomb) begin
              idx = tomb;
            end
            slot_key[idx] = key;
            slot_mark[idx] = MARK_USED;
            res.success = 1'b1;
            return res;
          end
        end
        if (have_tomb) begin
          slot_key[tomb] = key;
          slot_mark[tomb] = MARK_USED;
          res.success = 1'b1;
        end else begin
          res.status = ST_FULL;
        end
      end else if (kind == KIND_FIND || kind == KIND_DELETE) begin
        res.status = ST_MISSING;
        for (int unsigned step = 0; step < SLOTS; step++) begin
          idx = (start + step) % SLOTS;
          if (slot_mark[idx] == MARK_EMPTY) begin
            break;
          end
          if (slot_mark[idx] == MARK_USED && slot_key[idx] == key) begin
            if (kind == KIND_DELETE) begin
              slot_mark[idx] = MARK_DELETED;
            end
            res.success = 1'b1;
            res.status = ST_DONE;
            break;
          end
        end
      end
      return res;
    endfunction

    function void note_word(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
      pending_outcomes.push_back(predict_outcome(kind, key));
    endfunction

    function void check_result(logic success, logic [STATUS_W-1:0] status);
      outcome_t exp_res;
      if (pending_outcomes.size() == 0) begin
        $error("result word with nothing pending: success %0d, status %0d", success, status);
        failures++;
        return;
      end
      exp_res = pending_outcomes.pop_front();
      if (success !== exp_res.success) begin
        $error("success: expected %0d, actual %0d", exp_res.success, success);
        failures++;
      end
      if (status !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, status);
        failures++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [KEY_W-1:0]      s_axis_tdata_i;
  logic [KIND_W-1:0]     s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  key_set_checker board;
  int unsigned    src_gap_max;
  logic [3:0]     cluster_base;
  logic [KEY_W-1:0] key_pool [POOL];

  linear_probing_hash_set #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [KEY_W-1:0] pool_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    k[3:0] = 4'(cluster_base + $urandom_range(0, 3));
    return k;
  endfunction

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= key;
    s_axis_tuser_i <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_word(kind, key);
  endtask

  initial begin
    int unsigned insert_pct, pick;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    board = new();
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = KIND_INSERT;
    src_gap_max = 10;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Probe stops at an empty slot, then extremes that collide around the wrap.
    send_word(KIND_FIND, 32'd5);
    send_word(KIND_INSERT, 32'h8000_0000);
    send_word(KIND_INSERT, 32'h7FFF_FFFF);
    send_word(KIND_INSERT, 32'hFFFF_FFFF);
    send_word(KIND_INSERT, 32'h0000_0000);
    send_word(KIND_INSERT, 32'h7FFF_FFFF);
    send_word(KIND_DELETE, 32'h8000_0000);
    send_word(KIND_FIND, 32'h0000_0000);
    send_word(KIND_FIND, 32'h8000_0000);
    send_word(KIND_INSERT, 32'd16);
    send_word(KIND_NOP, 32'hA5A5_5A5A);
    for (int i = -6; i < 6; i++) begin
      send_word(KIND_INSERT, 32'(3 + 16 * i));
    end
    // The table is now full: no room, a miss over a whole lap, then a tombstone reused.
    send_word(KIND_INSERT, 32'd99);
    send_word(KIND_FIND, 32'd7);
    send_word(KIND_DELETE, 32'd3);
    send_word(KIND_INSERT, 32'd7);
    send_word(KIND_FIND, 32'd7);

    cluster_base = 4'($urandom);
    foreach (key_pool[i]) begin
      key_pool[i] = pool_key();
    end
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;

    for (int blk = 0; blk < 19; blk++) begin
      insert_pct = $urandom_range(15, 85);
      src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      cluster_base = 4'($urandom);
      for (int j = 0; j < 4; j++) begin
        key_pool[$urandom_range(0, POOL - 1)] = pool_key();
      end
      for (int n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          kind = KIND_NOP;
        end else if (pick < 3 + insert_pct) begin
          kind = KIND_INSERT;
        end else begin
          kind = ($urandom_range(0, 1) == 0) ? KIND_FIND : KIND_DELETE;
        end
        if ($urandom_range(0, 99) < 85) begin
          key = key_pool[$urandom_range(0, POOL - 1)];
        end else begin
          key = $urandom;
        end
        send_word(kind, key);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (board.pending_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SLOTS + 16) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    int unsigned stall_max, stall, taken;
    m_axis_tready_i <= 1'b0;
    stall_max = 10;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) begin
        stall_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      end
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      board.check_result(m_axis_tuser_o, m_axis_tdata_o[STATUS_W-1:0]);
      taken++;
    end
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
